FILE: src/tmcr_pkg.sv
package tmcr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  FLAG_DETECT  = 8'h80;
  localparam logic [7:0]  FLAG_PRESS   = 8'h40;
  localparam logic [7:0]  FLAG_RELEASE = 8'h20;
  localparam logic [7:0]  INVALID_ID   = 8'hff;
  localparam logic [15:0] SMALL_SCREEN = 16'd1024;
  localparam logic [7:0]  NEWER_AREA   = 8'd10;

  typedef enum logic [2:0] {
    CFG_LEGACY_MIN = 3'd0,
    CFG_LEGACY_MAX = 3'd1,
    CFG_NEWER_MIN  = 3'd2,
    CFG_NEWER_MAX  = 3'd3,
    CFG_SCREEN_X   = 3'd4,
    CFG_SCREEN_Y   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_LEGACY = 2'd1,
    OP_NEWER  = 2'd2
  } op_e;

  typedef struct packed {
    logic [7:0] source_id;
    logic [7:0] status_flags;
    logic [7:0] payload_a;
    logic [7:0] payload_b;
    logic [7:0] payload_c;
    logic [7:0] payload_d;
  } msg_t;

  typedef struct packed {
    logic        has_contact;
    logic [4:0]  contact_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  contact_area;
    logic        tip_down;
    logic [3:0]  contact_count;
    logic        last;
  } res_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  idx;
    logic [7:0]  flags;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  area;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  flags;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  area;
  } ent_t;

endpackage

FILE: src/tmcr_ram.sv
module tmcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tmcr_fifo.sv
module tmcr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: src/tmcr_front.sv
module tmcr_front #(
  parameter int unsigned TABLE_ENTRIES = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tmcr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tmcr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                push_i,
  input  tmcr_pkg::msg_t                      msg_i,
  input  logic                                cmd_full_i,
  output logic                                cmd_push_o,
  output tmcr_pkg::cmd_t                      cmd_o
);

  localparam logic [8:0] ENTRIES = 9'(TABLE_ENTRIES);

  logic [7:0]  leg_min_q, leg_max_q, new_min_q, new_max_q;
  logic [15:0] max_x_q, max_y_q;

  logic        leg_hit, new_hit, leg_ok, new_ok;
  logic [7:0]  leg_idx, new_off, new_idx;
  logic [11:0] leg_x, leg_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leg_min_q <= '0;
      leg_max_q <= '0;
      new_min_q <= '0;
      new_max_q <= '0;
      max_x_q   <= tmcr_pkg::SMALL_SCREEN;
      max_y_q   <= tmcr_pkg::SMALL_SCREEN;
    end else if (cfg_we_i) begin
      unique case (tmcr_pkg::cfg_idx_e'(cfg_idx_i))
        tmcr_pkg::CFG_LEGACY_MIN: leg_min_q <= cfg_wdata_i[7:0];
        tmcr_pkg::CFG_LEGACY_MAX: leg_max_q <= cfg_wdata_i[7:0];
        tmcr_pkg::CFG_NEWER_MIN:  new_min_q <= cfg_wdata_i[7:0];
        tmcr_pkg::CFG_NEWER_MAX:  new_max_q <= cfg_wdata_i[7:0];
        tmcr_pkg::CFG_SCREEN_X:   max_x_q   <= cfg_wdata_i;
        tmcr_pkg::CFG_SCREEN_Y:   max_y_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign leg_hit = (msg_i.source_id >= leg_min_q) && (msg_i.source_id <= leg_max_q);
  assign leg_idx = msg_i.source_id - leg_min_q;
  assign leg_ok  = ({1'b0, leg_idx} < ENTRIES);

  assign new_hit = (msg_i.source_id >= new_min_q) && (msg_i.source_id <= new_max_q);
  assign new_off = msg_i.source_id - new_min_q;
  assign new_idx = new_off - 8'd2;
  assign new_ok  = (new_off >= 8'd2) && ({1'b0, new_idx} < ENTRIES);

  assign leg_x = {msg_i.payload_a, msg_i.payload_c[7:4]};
  assign leg_y = {msg_i.payload_b, msg_i.payload_c[3:0]};

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = tmcr_pkg::OP_REPORT;
    cmd_o.flags = msg_i.status_flags;
    if (leg_hit) begin
      cmd_o.idx  = leg_idx;
      cmd_o.x    = (max_x_q < tmcr_pkg::SMALL_SCREEN) ? {6'd0, leg_x[11:2]} : {4'd0, leg_x};
      cmd_o.y    = (max_y_q < tmcr_pkg::SMALL_SCREEN) ? {6'd0, leg_y[11:2]} : {4'd0, leg_y};
      cmd_o.area = msg_i.payload_d;
      if (leg_ok) begin
        cmd_o.op = tmcr_pkg::OP_LEGACY;
      end
    end else if (new_hit && new_ok) begin
      cmd_o.op   = tmcr_pkg::OP_NEWER;
      cmd_o.idx  = new_idx;
      cmd_o.x    = {msg_i.payload_b, msg_i.payload_a};
      cmd_o.y    = {msg_i.payload_d, msg_i.payload_c};
      cmd_o.area = tmcr_pkg::NEWER_AREA;
    end
  end

  assign cmd_push_o = push_i && !cmd_full_i && (msg_i.source_id != tmcr_pkg::INVALID_ID);

endmodule

FILE: src/tmcr_back.sv
module tmcr_back #(
  parameter int unsigned TABLE_ENTRIES = 20,
  parameter int unsigned REPORT_SLOTS  = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  tmcr_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output tmcr_pkg::res_t res_o
);

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SLOT_W = $clog2(REPORT_SLOTS + 1);
  localparam int unsigned ENT_W  = $bits(tmcr_pkg::ent_t);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UPDATE = 6'b000010,
    S_PREP   = 6'b000100,
    S_EMPTY  = 6'b001000,
    S_SCAN   = 6'b010000,
    S_FETCH  = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  tmcr_pkg::cmd_t         cmd_q;
  logic [IDX_W-1:0]       scan_q, scan_d;
  logic [SLOT_W-1:0]      sent_q, sent_d, rpt_q, rpt_d;
  logic [3:0]             prev_q, prev_d;
  logic [TABLE_ENTRIES-1:0] active_q, active_d, det_q, det_d;
  logic [CNT_W-1:0]       act_cnt_q, act_cnt_d;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       widx;
  tmcr_pkg::ent_t         wr_ent, rd_ent;
  logic [7:0]             new_flags;
  logic                   new_act, tip, drop;

  assign widx = cmd_q.idx[IDX_W-1:0];

  always_comb begin
    new_flags = cmd_q.flags;
    if (cmd_q.op == tmcr_pkg::OP_NEWER) begin
      if (cmd_q.flags[7]) begin
        new_flags = tmcr_pkg::FLAG_DETECT;
      end else if (det_q[widx]) begin
        new_flags = tmcr_pkg::FLAG_RELEASE;
      end else begin
        new_flags = '0;
      end
    end
  end

  assign new_act       = (new_flags != '0);
  assign wr_ent.flags  = new_flags;
  assign wr_ent.x      = cmd_q.x;
  assign wr_ent.y      = cmd_q.y;
  assign wr_ent.area   = cmd_q.area;
  assign ram_we        = (state_q == S_UPDATE) && (cmd_q.op != tmcr_pkg::OP_REPORT);
  assign ram_re        = (state_q == S_SCAN) && active_q[scan_q] && !res_full_i;

  tmcr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (scan_q),
    .rdata_o (rd_ent)
  );

  assign tip  = |(rd_ent.flags & (tmcr_pkg::FLAG_DETECT | tmcr_pkg::FLAG_PRESS));
  assign drop = !tip && ((rd_ent.flags & tmcr_pkg::FLAG_RELEASE) != '0);

  always_comb begin
    res_o = '0;
    if (state_q == S_FETCH) begin
      res_o.has_contact   = 1'b1;
      res_o.contact_id    = 5'(scan_q);
      res_o.pos_x         = rd_ent.x;
      res_o.pos_y         = rd_ent.y;
      res_o.contact_area  = rd_ent.area;
      res_o.tip_down      = tip;
      res_o.contact_count = 4'(rpt_q);
      res_o.last          = (SLOT_W'(sent_q + 1'b1) == rpt_q);
    end else begin
      res_o.last          = 1'b1;
    end
  end

  assign res_push_o = (state_q == S_FETCH) || ((state_q == S_EMPTY) && !res_full_i);
  assign cmd_pop_o  = (state_q == S_IDLE) && !cmd_empty_i;

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    sent_d    = sent_q;
    rpt_d     = rpt_q;
    prev_d    = prev_q;
    active_d  = active_q;
    det_d     = det_q;
    act_cnt_d = act_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (ram_we) begin
          active_d[widx] = new_act;
          det_d[widx]    = new_flags[7];
          if (new_act && !active_q[widx]) begin
            act_cnt_d = act_cnt_q + 1'b1;
          end else if (!new_act && active_q[widx]) begin
            act_cnt_d = act_cnt_q - 1'b1;
          end
        end
        state_d = S_PREP;
      end
      S_PREP: begin
        scan_d = '0;
        sent_d = '0;
        rpt_d  = (act_cnt_q > CNT_W'(REPORT_SLOTS)) ? SLOT_W'(REPORT_SLOTS)
                                                    : SLOT_W'(act_cnt_q);
        if (act_cnt_q != '0) begin
          state_d = S_SCAN;
        end else if (prev_q != '0) begin
          state_d = S_EMPTY;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (!res_full_i) begin
          prev_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!active_q[scan_q]) begin
          scan_d = scan_q + 1'b1;
        end else if (!res_full_i) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        if (drop) begin
          active_d[scan_q] = 1'b0;
          det_d[scan_q]    = 1'b0;
          act_cnt_d        = act_cnt_q - 1'b1;
        end
        sent_d = sent_q + 1'b1;
        scan_d = scan_q + 1'b1;
        if (res_o.last) begin
          prev_d  = 4'(rpt_q);
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      scan_q    <= '0;
      sent_q    <= '0;
      rpt_q     <= '0;
      prev_q    <= '0;
      active_q  <= '0;
      det_q     <= '0;
      act_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      sent_q    <= sent_d;
      rpt_q     <= rpt_d;
      prev_q    <= prev_d;
      active_q  <= active_d;
      det_q     <= det_d;
      act_cnt_q <= act_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_cnt_q == CNT_W'($countones(active_q)))
    else $error("active count out of step with active bits");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_FETCH) |-> (32'(scan_q) < TABLE_ENTRIES))
    else $error("scan ran past the table");

  a_sent_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_FETCH) |-> (sent_q < rpt_q))
    else $error("more contacts sent than counted");

  a_fetch_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> !res_full_i)
    else $error("result queue full at fetch");

  a_read_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (state_q == S_FETCH) && (rd_ent.flags != '0))
    else $error("fetched entry is not active");

endmodule

FILE: src/touch_message_contact_reporter.sv
// channel  ports                          transaction
// message  push, full, msg_i              push && !full
// result   empty, pop, res_o              pop && !empty
// config   cfg_we_i, cfg_idx_i, cfg_wdata_i  cfg_we_i
//
// A message is popped in S_IDLE, written to the table in S_UPDATE, and the report
// is sized in S_PREP; the scan then steps through entries up to the last reported
// contact, fetching at most REPORT_SLOTS contacts; an empty report is one result.
// Reset clears the contact table at once through per-entry active bits.
// A two-entry command queue lets messages arrive while the table scan runs;
// a full result queue holds the scan on its current entry.
module touch_message_contact_reporter #(
  parameter int unsigned TABLE_ENTRIES = 20,
  parameter int unsigned REPORT_SLOTS  = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tmcr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tmcr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  tmcr_pkg::msg_t                  msg_i,
  output logic                            empty,
  input  logic                            pop,
  output tmcr_pkg::res_t                  res_o
);

  tmcr_pkg::cmd_t cmd_in, cmd_out;
  tmcr_pkg::res_t res_in;
  logic           cmd_push, cmd_pop, cmd_empty;
  logic           res_push, res_full;

  tmcr_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .msg_i       (msg_i),
    .cmd_full_i  (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  tmcr_fifo #(
    .WIDTH ($bits(tmcr_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  tmcr_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .REPORT_SLOTS  (REPORT_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  tmcr_fifo #(
    .WIDTH ($bits(tmcr_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_o),
    .empty_o (empty)
  );

endmodule
